>>> src/lla_pkg.sv
// Shared types, constants and helper functions of the life-like automaton row engine.
// Used by every module of the block; it depends on nothing else.
package lla_pkg;

  localparam int AGE_LEVELS = 8;
  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int MIN_SIZE   = 6;

  localparam int CELL_W = 3;
  localparam int SIZE_W = 11;
  localparam int CNT_W  = $clog2((MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS);
  localparam int NBR_W  = 4;

  // Top age level, limited by the cell field width.
  localparam int AGE_TOP_I = (AGE_LEVELS - 1 > (1 << CELL_W) - 1) ?
                             (1 << CELL_W) - 1 : AGE_LEVELS - 1;
  localparam logic [CELL_W-1:0] AGE_TOP = CELL_W'(AGE_TOP_I);

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RULE_SELECT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AGE_MODE    = 2'd3;

  localparam logic [SIZE_W-1:0] NUM_ROWS_RESET = 11'd64;
  localparam logic [SIZE_W-1:0] NUM_COLS_RESET = 11'd64;

  // Output queue geometry.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    RULE_LIFE   = 2'd0,
    RULE_CORAL  = 2'd1,
    RULE_AMOEBA = 2'd2,
    RULE_MAZE   = 2'd3
  } rule_t;

  // One column slice of three cells.
  typedef struct packed {
    logic [CELL_W-1:0] top;
    logic [CELL_W-1:0] mid;
    logic [CELL_W-1:0] bot;
  } slice_t;

  // Registered 3x3 window plus the control flags that go with it.
  typedef struct packed {
    slice_t left;
    slice_t center;
    slice_t right;
    logic   has_cell;
    logic   border;
    logic   last_col;
    logic   last_row;
  } win_t;

  // One result request.
  typedef struct packed {
    logic [CELL_W-1:0] new_cell;
    logic              last_in_row;
    logic              last_in_frame;
  } res_t;

  // Turns a size register into the last valid index, with out of range sizes clamped.
  function automatic logic [CNT_W-1:0] last_index(input logic [SIZE_W-1:0] size,
                                                   input int maxv);
    logic [CNT_W-1:0] r;
    if (size < SIZE_W'(MIN_SIZE)) begin
      r = CNT_W'(MIN_SIZE - 1);
    end else if (size > SIZE_W'(maxv)) begin
      r = CNT_W'(maxv - 1);
    end else begin
      r = CNT_W'(size - SIZE_W'(1));
    end
    return r;
  endfunction

  // Number of live cells in a slice.
  function automatic logic [1:0] live3(input slice_t s);
    return 2'({1'b0, s.top != '0} + {1'b0, s.mid != '0} + {1'b0, s.bot != '0});
  endfunction

endpackage

>>> src/lla_window.sv
// Input register stage: column and row counters, the sliding slice window and border flags.
// Depends on lla_pkg.
module lla_window (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lla_pkg::slice_t             in_slice,
  input  logic [lla_pkg::SIZE_W-1:0]  num_rows,
  input  logic [lla_pkg::SIZE_W-1:0]  num_cols,
  input  logic                        drain,
  output logic                        win_valid,
  output lla_pkg::win_t               win
);

  logic [lla_pkg::CNT_W-1:0] column_count;
  logic [lla_pkg::CNT_W-1:0] row_count;
  lla_pkg::slice_t           window_left;
  lla_pkg::slice_t           window_center;
  logic [lla_pkg::CNT_W-1:0] rows_last;
  logic [lla_pkg::CNT_W-1:0] cols_last;
  logic                      accept;
  logic                      last_col;
  logic                      last_row;
  logic                      row_border;

  assign rows_last  = lla_pkg::last_index(num_rows, lla_pkg::MAX_ROWS);
  assign cols_last  = lla_pkg::last_index(num_cols, lla_pkg::MAX_COLS);
  assign last_col   = column_count >= cols_last;
  assign last_row   = row_count >= rows_last;
  assign row_border = (row_count == '0) || last_row;

  // The stage takes a new slice when it is empty or hands its content on this cycle.
  assign in_ready = !win_valid || drain;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid     <= 1'b0;
      column_count  <= '0;
      row_count     <= '0;
      window_left   <= '0;
      window_center <= '0;
    end else begin
      if (accept) begin
        win_valid     <= 1'b1;
        window_left   <= window_center;
        window_center <= in_slice;
        if (last_col) begin
          column_count <= '0;
          row_count    <= last_row ? '0 : row_count + 1'b1;
        end else begin
          column_count <= column_count + 1'b1;
        end
      end else if (drain) begin
        win_valid <= 1'b0;
      end
    end
  end

  // Window payload; the column being decided is the one before the incoming slice.
  always_ff @(posedge clk) begin
    if (accept) begin
      win.left     <= window_left;
      win.center   <= window_center;
      win.right    <= in_slice;
      win.has_cell <= column_count != '0;
      win.border   <= row_border || (column_count == lla_pkg::CNT_W'(1));
      win.last_col <= last_col;
      win.last_row <= last_row;
    end
  end

endmodule

>>> src/lla_rule.sv
// Neighbor count and birth/survival rule for the center cell of the window, with aging.
// Depends on lla_pkg.
module lla_rule (
  input  lla_pkg::win_t               win,
  input  lla_pkg::rule_t              rule_select,
  input  logic                        age_mode,
  output logic [lla_pkg::CELL_W-1:0]  new_cell
);

  logic [lla_pkg::NBR_W-1:0]  count;
  logic [lla_pkg::CELL_W-1:0] mid;
  logic                       alive;

  assign mid   = win.center.mid;
  // The center cell itself is left out of the count.
  assign count = lla_pkg::NBR_W'(lla_pkg::live3(win.left)) +
                 lla_pkg::NBR_W'(lla_pkg::live3(win.right)) +
                 lla_pkg::NBR_W'(win.center.top != '0) +
                 lla_pkg::NBR_W'(win.center.bot != '0);

  always_comb begin
    case (rule_select)
      lla_pkg::RULE_LIFE: begin
        alive = (mid != '0) ? (count inside {4'd2, 4'd3}) : (count == 4'd3);
      end
      lla_pkg::RULE_CORAL: begin
        alive = (mid != '0) ? (count > 4'd3) : (count == 4'd3);
      end
      lla_pkg::RULE_AMOEBA: begin
        alive = (mid != '0) ? (count inside {4'd1, 4'd3, 4'd5, 4'd8})
                            : (count inside {4'd3, 4'd5, 4'd7});
      end
      lla_pkg::RULE_MAZE: begin
        alive = (mid != '0) ? (count inside {[4'd1:4'd5]}) : (count == 4'd3);
      end
      default: begin
        alive = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (win.border || !alive) begin
      new_cell = '0;
    end else if (!age_mode) begin
      new_cell = lla_pkg::CELL_W'(1);
    end else if (mid < lla_pkg::AGE_TOP) begin
      new_cell = mid + lla_pkg::CELL_W'(1);
    end else begin
      new_cell = lla_pkg::AGE_TOP;
    end
  end

endmodule

>>> src/lla_out_queue.sv
// Small result queue that takes up to two result requests per cycle and hands out one.
// Depends on lla_pkg.
module lla_out_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_a,
  input  lla_pkg::res_t   data_a,
  input  logic            push_b,
  input  lla_pkg::res_t   data_b,
  output logic            room2,
  output logic            out_valid,
  input  logic            out_ready,
  output lla_pkg::res_t   out_data
);

  lla_pkg::res_t             entries [lla_pkg::OQ_DEPTH];
  logic [lla_pkg::OQ_AW-1:0] wr_ptr;
  logic [lla_pkg::OQ_AW-1:0] wr_ptr_b;
  logic [lla_pkg::OQ_AW-1:0] rd_ptr;
  logic [lla_pkg::OQ_CW-1:0] count;
  logic [1:0]                n_push;
  logic                      pop;

  assign out_valid = count != '0;
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign room2     = count <= lla_pkg::OQ_CW'(lla_pkg::OQ_DEPTH - 2);
  assign n_push    = {1'b0, push_a} + {1'b0, push_b};
  // The second request lands right behind the first when both arrive together.
  assign wr_ptr_b  = wr_ptr + lla_pkg::OQ_AW'(push_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + lla_pkg::OQ_AW'(n_push);
      rd_ptr <= rd_ptr + lla_pkg::OQ_AW'(pop);
      count  <= count + lla_pkg::OQ_CW'(n_push) - lla_pkg::OQ_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      entries[wr_ptr] <= data_a;
    end
    if (push_b) begin
      entries[wr_ptr_b] <= data_b;
    end
  end

endmodule

>>> src/life_like_automaton_row_engine_core.sv
// Top level of the life-like automaton row engine: configuration registers and stage wiring.
// Depends on lla_pkg, lla_window, lla_rule and lla_out_queue.

// The engine takes one column slice (cells above, at and below the current row)
// per request and can accept a new slice in every clock cycle while the output
// queue has room. Each slice is registered together with the two previous
// slices; the next cycle the 3x3 window is counted, the selected rule (Life
// B3/S23, Coral B3/S45678, Amoeba B357/S1358 or Maze B3/S12345) is applied and
// the result goes into a four-entry output queue when it has room for two, so
// a result passes the window register and a queue entry before it is offered
// and can be taken at the following clock edge. The slice at column j gives
// the result for column j-1; the first slice of a row gives no result and the last
// one gives two (its predecessor and the always-dead last column), so every row of
// num_cols slices yields num_cols results and the sustained rate is one slice per
// cycle as long as the downstream side takes one result per cycle. The input stage
// only moves on when the queue has room for two results, which is what throttles
// the input when the output side stalls. Cells on the first and last rows and
// columns are always dead. With age_mode set, a live cell reports its age, counting up from
// 1 and saturating at the top level. Configuration writes take effect at once
// and are meant to be done only while the engine is idle.
module life_like_automaton_row_engine_core (
  input  logic                           clk,
  input  logic                           rst,
  // Input slice stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,  // top_cell, middle_cell, bottom_cell
  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // new_cell
  output logic                           m_axis_tlast,  // last_in_row
  output logic [0:0]                     m_axis_tuser,  // last_in_frame
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [lla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lla_pkg::SIZE_W-1:0]     cfg_data
);

  logic [lla_pkg::SIZE_W-1:0]  num_rows;
  logic [lla_pkg::SIZE_W-1:0]  num_cols;
  lla_pkg::rule_t              rule_select;
  logic                        age_mode;

  lla_pkg::slice_t             in_slice;
  lla_pkg::win_t               win;
  logic                        win_valid;
  logic                        drain;
  logic                        room2;
  logic [lla_pkg::CELL_W-1:0]  new_cell;
  lla_pkg::res_t               res_cell;
  lla_pkg::res_t               res_end;
  lla_pkg::res_t               out_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows    <= lla_pkg::NUM_ROWS_RESET;
      num_cols    <= lla_pkg::NUM_COLS_RESET;
      rule_select <= lla_pkg::RULE_LIFE;
      age_mode    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        lla_pkg::REG_NUM_ROWS:    num_rows    <= cfg_data;
        lla_pkg::REG_NUM_COLS:    num_cols    <= cfg_data;
        lla_pkg::REG_RULE_SELECT: rule_select <= lla_pkg::rule_t'(cfg_data[1:0]);
        lla_pkg::REG_AGE_MODE:    age_mode    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign in_slice.top = s_axis_tdata[2:0];
  assign in_slice.mid = s_axis_tdata[5:3];
  assign in_slice.bot = s_axis_tdata[8:6];

  lla_window u_window (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_slice  (in_slice),
    .num_rows  (num_rows),
    .num_cols  (num_cols),
    .drain     (drain),
    .win_valid (win_valid),
    .win       (win)
  );

  lla_rule u_rule (
    .win         (win),
    .rule_select (rule_select),
    .age_mode    (age_mode),
    .new_cell    (new_cell)
  );

  // The window stage hands over only when the queue can take both possible results.
  assign drain = win_valid && room2;

  // First request: the decided cell of the previous column.
  assign res_cell.new_cell      = new_cell;
  assign res_cell.last_in_row   = 1'b0;
  assign res_cell.last_in_frame = 1'b0;

  // Second request: the always-dead last column of the row.
  assign res_end.new_cell      = '0;
  assign res_end.last_in_row   = 1'b1;
  assign res_end.last_in_frame = win.last_row;

  lla_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push_a    (drain && win.has_cell),
    .data_a    (res_cell),
    .push_b    (drain && win.last_col),
    .data_b    (res_end),
    .room2     (room2),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = {5'd0, out_data.new_cell};
  assign m_axis_tlast = out_data.last_in_row;
  assign m_axis_tuser = out_data.last_in_frame;

endmodule

>>> bench/tb_life_like_automaton_row_engine_core.sv
// Self-checking bench for life_like_automaton_row_engine_core: streams column slices,
// predicts each next-generation cell in a scoreboard class and compares every result.
// Depends on lla_pkg and the core RTL only.
module tb_life_like_automaton_row_engine_core;
  import lla_pkg::*;

  // Scoreboard: keeps its own copy of the registers, the column and row position
  // and the two previous slices, and queues the results every accepted slice causes.
  class next_gen_board;
    logic [SIZE_W-1:0] rows_reg;
    logic [SIZE_W-1:0] cols_reg;
    rule_t             rule_sel;
    logic              age_on;
    int unsigned       col_idx;
    int unsigned       row_idx;
    slice_t            left_slice;
    slice_t            center_slice;
    res_t              expected_cells[$];
    int                mismatches;

    function new();
      rows_reg     = NUM_ROWS_RESET;
      cols_reg     = NUM_COLS_RESET;
      rule_sel     = RULE_LIFE;
      age_on       = 1'b0;
      col_idx      = 0;
      row_idx      = 0;
      left_slice   = '0;
      center_slice = '0;
      mismatches   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
      case (idx)
        REG_NUM_ROWS:    rows_reg = data;
        REG_NUM_COLS:    cols_reg = data;
        REG_RULE_SELECT: rule_sel = rule_t'(data[1:0]);
        REG_AGE_MODE:    age_on   = data[0];
        default: ;
      endcase
    endfunction

    function int occupied(slice_t s);
      return int'(s.top != '0) + int'(s.mid != '0) + int'(s.bot != '0);
    endfunction

    // Works out what one accepted slice releases: the finished cell one column
    // back (if any) and, at the row's last column, the always-dead last cell.
    function void note_slice(slice_t incoming);
      int unsigned       rows_lim;
      int unsigned       cols_lim;
      bit                row_border;
      bit                last_col;
      bit                last_row;
      bit                alive;
      int                nbrs;
      logic [CELL_W-1:0] mid;
      logic [CELL_W-1:0] next_val;
      res_t              r;
      // Sizes out of range behave as the nearest legal size.
      rows_lim = (rows_reg < MIN_SIZE) ? MIN_SIZE : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
      cols_lim = (cols_reg < MIN_SIZE) ? MIN_SIZE : (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
      // A counter at or past the last index (size shrunk mid-frame) counts as the last.
      last_col   = col_idx >= cols_lim - 1;
      last_row   = row_idx >= rows_lim - 1;
      row_border = (row_idx == 0) || last_row;
      if (col_idx >= 1) begin
        next_val = '0;
        if (!row_border && col_idx != 1) begin
          mid   = center_slice.mid;
          nbrs  = occupied(left_slice) + occupied(incoming) +
                  int'(center_slice.top != '0) + int'(center_slice.bot != '0);
          alive = 1'b0;
          case (rule_sel)
            RULE_LIFE:   alive = (mid != '0) ? (nbrs == 2 || nbrs == 3) : (nbrs == 3);
            RULE_CORAL:  alive = (mid != '0) ? (nbrs > 3) : (nbrs == 3);
            RULE_AMOEBA: alive = (mid != '0) ? (nbrs == 1 || nbrs == 3 || nbrs == 5 || nbrs == 8)
                                             : (nbrs == 3 || nbrs == 5 || nbrs == 7);
            default:     alive = (mid != '0) ? (nbrs >= 1 && nbrs <= 5) : (nbrs == 3);
          endcase
          if (alive) begin
            if (!age_on) next_val = 3'd1;
            else next_val = (mid < AGE_TOP) ? mid + 3'd1 : AGE_TOP;
          end
        end
        r = '{new_cell: next_val, last_in_row: 1'b0, last_in_frame: 1'b0};
        expected_cells.push_back(r);
      end
      if (last_col) begin
        r = '{new_cell: '0, last_in_row: 1'b1, last_in_frame: last_row};
        expected_cells.push_back(r);
      end
      left_slice   = center_slice;
      center_slice = incoming;
      if (last_col) begin
        col_idx = 0;
        row_idx = last_row ? 0 : row_idx + 1;
      end else begin
        col_idx++;
      end
    endfunction

    function void check_cell(logic [CELL_W-1:0] got_cell, logic got_lr, logic got_lf);
      res_t want;
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual new_cell=%0d last_in_row=%0b last_in_frame=%0b",
                 $time, got_cell, got_lr, got_lf);
        mismatches++;
        return;
      end
      want = expected_cells.pop_front();
      if (want.new_cell !== got_cell) begin
        $display("%0t: new_cell mismatch: expected %0d, actual %0d", $time, want.new_cell, got_cell);
        mismatches++;
      end
      if (want.last_in_row !== got_lr) begin
        $display("%0t: last_in_row mismatch: expected %0b, actual %0b",
                 $time, want.last_in_row, got_lr);
        mismatches++;
      end
      if (want.last_in_frame !== got_lf) begin
        $display("%0t: last_in_frame mismatch: expected %0b, actual %0b",
                 $time, want.last_in_frame, got_lf);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [7:0]           m_axis_tdata;
  logic                 m_axis_tlast;
  logic [0:0]           m_axis_tuser;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  next_gen_board board;
  // Chance, in percent, that an idle burst starts before a slice (input) or at an edge (output).
  int gap_pct     = 0;
  int stall_pct   = 0;
  int slices_sent = 0;

  life_like_automaton_row_engine_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Every result request that completes at a clock edge goes to the scoreboard.
  // All inputs change through nonblocking assignments, so the values seen right
  // after the edge are the ones the block saw at it.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      board.check_cell(m_axis_tdata[CELL_W-1:0], m_axis_tlast, m_axis_tuser[0]);
    end
  end

  // Output backpressure: tready drops for bursts of random length. After a burst
  // the loop first moves to the next edge, so tready never gets two updates in
  // one time step.
  initial begin
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offers one slice and waits for its request to be taken. tvalid stays high
  // afterwards, so back-to-back slices go out without a bubble; it only drops
  // for an idle burst or when the bench settles.
  task automatic send_slice(input slice_t s);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    // Fields from the lowest bit up: top_cell, middle_cell, bottom_cell.
    s_axis_tdata  <= {7'b0, s.bot, s.mid, s.top};
    do @(posedge clk); while (!s_axis_tready);
    board.note_slice(s);
    slices_sent++;
  endtask

  // Stops the input and waits until every expected cell has come out. A slice at
  // column zero produces nothing, so it then also lets the pipeline run empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (board.expected_cells.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.set_reg(idx, data);
  endtask

  // Registers are only touched once the engine is idle; the position inside the
  // frame is kept, so shrinking a size here exercises the counter wrap.
  task automatic configure(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols,
                           input rule_t rule_sel, input logic age);
    settle();
    write_reg(REG_NUM_ROWS, rows);
    write_reg(REG_NUM_COLS, cols);
    write_reg(REG_RULE_SELECT, SIZE_W'(rule_sel));
    write_reg(REG_AGE_MODE, SIZE_W'(age));
    cfg_we <= 1'b0;
  endtask

  // One setting, then a run of random slices. Each cell is live with the given
  // density and carries a random age of 1 to 7, so all neighbor counts from 0 to
  // 8 and every bit of every field come up over the run.
  task automatic run_phase(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols,
                           input rule_t rule_sel, input logic age, input int n,
                           input int live_pct);
    slice_t s;
    configure(rows, cols, rule_sel, age);
    repeat (n) begin
      s.top = ($urandom_range(1, 100) <= live_pct) ? CELL_W'($urandom_range(1, 7)) : '0;
      s.mid = ($urandom_range(1, 100) <= live_pct) ? CELL_W'($urandom_range(1, 7)) : '0;
      s.bot = ($urandom_range(1, 100) <= live_pct) ? CELL_W'($urandom_range(1, 7)) : '0;
      send_slice(s);
    end
  endtask

  initial begin
    slice_t            pattern[8];
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
    int                pick;

    board = new();
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_NUM_ROWS;
    cfg_data      <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the smallest grid with ages on. Row zero is all live to
    // show the border forcing dead cells; the following rows mix empty, full and
    // single-bit slices, so a live center of 1 ages to 2 and one of 7 saturates.
    pattern = '{'{3'd0, 3'd0, 3'd0}, '{3'd7, 3'd7, 3'd7}, '{3'd1, 3'd2, 3'd4},
                '{3'd4, 3'd1, 3'd2}, '{3'd7, 3'd0, 3'd7}, '{3'd0, 3'd7, 3'd0},
                '{3'd2, 3'd4, 3'd1}, '{3'd7, 3'd7, 3'd0}};
    gap_pct   = 15;
    stall_pct = 15;
    configure(11'd6, 11'd6, RULE_LIFE, 1'b1);
    for (int i = 0; i < 24; i++) begin
      send_slice((i < 6) ? pattern[1] : pattern[(i * 5) % 8]);
    end

    // Extremes of the registers: smallest sizes, sizes below the minimum (act as
    // 6), above the maximum (act as 1024), the largest legal size, and a shrink
    // while the column counter sits past the new last index.
    run_phase(11'd6, 11'd6, RULE_LIFE, 1'b0, 40, 50);
    run_phase(11'd0, 11'd3, RULE_CORAL, 1'b1, 40, 70);
    run_phase(11'd2047, 11'd9, RULE_AMOEBA, 1'b1, 50, 45);
    gap_pct   = 0;
    stall_pct = 0;
    run_phase(11'd1024, 11'd2047, RULE_MAZE, 1'b0, 40, 60);
    gap_pct   = 25;
    stall_pct = 25;
    run_phase(11'd7, 11'd6, RULE_MAZE, 1'b1, 40, 40);

    // Random settings. Grids are mostly small so that interior cells and frame
    // ends come often; the last stretch runs at full rate without idling.
    while (slices_sent < 720) begin
      if (slices_sent >= 620) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        pick      = $urandom_range(0, 2);
        gap_pct   = (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
        pick      = $urandom_range(0, 2);
        stall_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
      end
      pick = $urandom_range(0, 11);
      rows = (pick == 0) ? SIZE_W'($urandom_range(0, 5)) :
             (pick == 1) ? SIZE_W'($urandom_range(1025, 2047)) :
                           SIZE_W'($urandom_range(6, 11));
      pick = $urandom_range(0, 11);
      cols = (pick == 0) ? SIZE_W'($urandom_range(0, 5)) :
             (pick == 1) ? SIZE_W'($urandom_range(1000, 2047)) :
                           SIZE_W'($urandom_range(6, 11));
      run_phase(rows, cols, rule_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                $urandom_range(15, 60), $urandom_range(10, 90));
    end

    s_axis_tvalid <= 1'b0;
    while (board.expected_cells.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("PASS life_like_automaton_row_engine_core");
    end else begin
      $display("FAIL life_like_automaton_row_engine_core");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #4000000;
    $display("FAIL life_like_automaton_row_engine_core");
    $finish;
  end

endmodule
